FILE: hdl/dds_pkg.sv
`default_nettype none

package dds_pkg;

  typedef enum logic [1:0] {
    ADDR_CTRL  = 2'b00,
    ADDR_FREQ0 = 2'b01,
    ADDR_FREQ1 = 2'b10,
    ADDR_PHASE = 2'b11
  } addr_t;

  localparam int unsigned CTL_B28_BIT     = 13;
  localparam int unsigned CTL_HLB_BIT     = 12;
  localparam int unsigned CTL_FSEL_BIT    = 11;
  localparam int unsigned CTL_PSEL_BIT    = 10;
  localparam int unsigned CTL_RESET_BIT   = 8;
  localparam int unsigned CTL_SLEEP1_BIT  = 7;
  localparam int unsigned CTL_SLEEP12_BIT = 6;
  localparam int unsigned CTL_MODE_BIT    = 1;
  localparam int unsigned PHASE_SEL_BIT   = 13;

  localparam int unsigned HALF_BITS  = 14;
  localparam int unsigned FREQ_BITS  = 28;
  localparam int unsigned PWORD_BITS = 12;
  localparam int unsigned OUT_BITS   = 12;

  localparam logic [HALF_BITS-1:0] CTL_RESET_VALUE = 14'h0100;

  typedef struct packed {
    logic [OUT_BITS-1:0] phase_out;
    logic                triangle_mode;
    logic                dac_enabled;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/dds_regfile.sv
`default_nettype none

module dds_regfile #(
  parameter int unsigned ACC_BITS   = 28,
  parameter int unsigned PHASE_BITS = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic            operation,
  input  wire logic [15:0]     reg_word,
  output dds_pkg::result_t     res
);
  import dds_pkg::*;

  logic [HALF_BITS-1:0]  ctl, ctl_next;
  logic [FREQ_BITS-1:0]  freq [2];
  logic [FREQ_BITS-1:0]  freq_next [2];
  logic [PWORD_BITS-1:0] phase [2];
  logic [PWORD_BITS-1:0] phase_next [2];
  logic [ACC_BITS-1:0]   acc, acc_next;
  logic                  expect_high, expect_high_next;
  logic [HALF_BITS-1:0]  held_low, held_low_next;

  addr_t                 addr;
  logic [HALF_BITS-1:0]  data;
  logic                  fidx;
  logic [PWORD_BITS-1:0] pword;
  logic [FREQ_BITS-1:0]  pword_aligned;
  logic [PHASE_BITS-1:0] offset;
  logic [PHASE_BITS-1:0] phase_sum;

  assign addr = addr_t'(reg_word[15:14]);
  assign data = reg_word[HALF_BITS-1:0];
  assign fidx = (addr == ADDR_FREQ1);

  always_comb begin
    ctl_next         = ctl;
    freq_next        = freq;
    phase_next       = phase;
    acc_next         = acc;
    expect_high_next = expect_high;
    held_low_next    = held_low;
    if (!operation) begin
      unique case (addr) inside
        ADDR_CTRL: begin
          ctl_next         = data;
          expect_high_next = 1'b0;
        end
        ADDR_FREQ0, ADDR_FREQ1: begin
          if (ctl[CTL_B28_BIT]) begin
            if (!expect_high) begin
              held_low_next    = data;
              expect_high_next = 1'b1;
            end else begin
              freq_next[fidx]  = {data, held_low};
              expect_high_next = 1'b0;
            end
          end else if (ctl[CTL_HLB_BIT]) begin
            freq_next[fidx] = {data, freq[fidx][HALF_BITS-1:0]};
          end else begin
            freq_next[fidx] = {freq[fidx][FREQ_BITS-1:HALF_BITS], data};
          end
        end
        ADDR_PHASE: begin
          phase_next[reg_word[PHASE_SEL_BIT]] = reg_word[PWORD_BITS-1:0];
        end
        default: begin
          ctl_next = ctl;
        end
      endcase
    end else if (!ctl[CTL_RESET_BIT] && !ctl[CTL_SLEEP1_BIT]) begin
      acc_next = acc + ACC_BITS'(freq[ctl[CTL_FSEL_BIT]]);
    end
    if (ctl_next[CTL_RESET_BIT]) begin
      acc_next = '0;
    end
  end

  // The phase word is twelve bits wide and is aligned to the top of the phase field.
  assign pword         = phase_next[ctl_next[CTL_PSEL_BIT]];
  assign pword_aligned = {pword, {(FREQ_BITS - PWORD_BITS){1'b0}}};
  assign offset        = pword_aligned[FREQ_BITS-1 -: PHASE_BITS];
  assign phase_sum     = acc_next[ACC_BITS-1 -: PHASE_BITS] + offset;

  always_comb begin
    res.phase_out     = OUT_BITS'(phase_sum);
    res.triangle_mode = ctl_next[CTL_MODE_BIT];
    res.dac_enabled   = !ctl_next[CTL_SLEEP12_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl         <= CTL_RESET_VALUE;
      freq[0]     <= '0;
      freq[1]     <= '0;
      phase[0]    <= '0;
      phase[1]    <= '0;
      acc         <= '0;
      expect_high <= 1'b0;
      held_low    <= '0;
    end else if (fire) begin
      ctl         <= ctl_next;
      freq        <= freq_next;
      phase       <= phase_next;
      acc         <= acc_next;
      expect_high <= expect_high_next;
      held_low    <= held_low_next;
    end
  end

  a_reset_holds_acc: assert property (@(posedge clk) disable iff (rst)
    ctl[CTL_RESET_BIT] |-> (acc == '0))
    else $error("Accumulator is not zero while the reset bit is set.");

  a_pairing_needs_b28: assert property (@(posedge clk) disable iff (rst)
    expect_high |-> ctl[CTL_B28_BIT])
    else $error("A high half is awaited although B28 is clear.");

endmodule

`default_nettype wire

FILE: hdl/dds_out_buf.sv
`default_nettype none

module dds_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire dds_pkg::result_t res,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output dds_pkg::result_t      out_res
);
  import dds_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid;
      end else if (load) begin
        out_res <= res;
      end
    end else if (load) begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid stage holds a beat while the output stage is empty.");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (!skid_valid && out_valid))
    else $error("Skid stage did not drain into the output stage.");

endmodule

`default_nettype wire

FILE: hdl/dds_register_file_and_phase_accumulator.sv
`default_nettype none

// Channel | Handshake              | Beat
// input   | in_valid / in_stall    | operation, reg_word
// output  | out_valid / out_stall  | phase_out, triangle_mode, dac_enabled
//
// One beat is accepted per cycle unless stalled; it passes the s1 and output registers.
// The cycle is set by the accumulator add followed by the phase offset add.
// Reset is synchronous and restores the register file, accumulator and buffers.
// The output has a skid stage, so input stalls only once two results wait.

module dds_register_file_and_phase_accumulator #(
  parameter int unsigned ACC_BITS   = 28,
  parameter int unsigned PHASE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [15:0] reg_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      phase_out,
  output logic             triangle_mode,
  output logic             dac_enabled
);
  import dds_pkg::*;

  logic        s1_valid;
  logic        s1_operation;
  logic [15:0] s1_word;
  logic        buf_full;
  logic        fire;
  result_t     res;
  result_t     out_res;

  assign in_stall = s1_valid && buf_full;
  assign fire     = s1_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_operation <= operation;
      s1_word      <= reg_word;
    end
  end

  dds_regfile #(
    .ACC_BITS   (ACC_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .operation (s1_operation),
    .reg_word  (s1_word),
    .res       (res)
  );

  dds_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign phase_out     = out_res.phase_out;
  assign triangle_mode = out_res.triangle_mode;
  assign dac_enabled   = out_res.dac_enabled;

endmodule

`default_nettype wire
